>>> hdl/blinn_phong_light_accumulator_assert.svh
// ---------------------------------------------------------------------------
// Blinn-Phong accumulator assertion macros
// Immediate-consequence and next-cycle property wrappers on clk and rst_n.
// ---------------------------------------------------------------------------
`ifndef BLINN_PHONG_LIGHT_ACCUMULATOR_ASSERT_SVH
`define BLINN_PHONG_LIGHT_ACCUMULATOR_ASSERT_SVH

// consequence holds in the same cycle
`define BPL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequence holds in the following cycle
`define BPL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/bpl_pkg.sv
// ---------------------------------------------------------------------------
// Blinn-Phong accumulator package
// Shared constants, controller/datapath command types and table builders.
// ---------------------------------------------------------------------------
package bpl_pkg;

  localparam int unsigned LOG_TABLE_DEPTH = 64;
  localparam int unsigned NUM_REGS        = 7;
  localparam int unsigned STEP_W          = 5;

  localparam logic [15:0] REFL_RESET = 16'd32768;
  localparam logic [15:0] SHIN_RESET = 16'd8192;

  typedef struct packed {
    logic              load;
    logic              dot;
    logic              sqrt;
    logic              div;
    logic              pow_log;
    logic              pow_mul;
    logic              pow_exp;
    logic              term;
    logic              emit;
    logic [STEP_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic lit;
    logic last;
    logic need_root;
  } sts_t;

  function automatic longint unsigned udiv64(input longint unsigned a,
                                             input longint unsigned b);
    longint unsigned q;
    longint unsigned rm;
    q  = 0;
    rm = 0;
    for (int i = 63; i >= 0; i--) begin
      rm = (rm << 1) | ((a >> i) & 64'd1);
      if (rm >= b) begin
        rm = rm - b;
        q  = q | (64'd1 << i);
      end
    end
    return q;
  endfunction

  function automatic longint unsigned isqrt64(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    longint unsigned x;
    r = 0;
    b = 64'd1 << 62;
    x = v;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // log2(1 + i/d) in Q.16 by repeated squaring
  function automatic longint unsigned log_entry(input longint unsigned i,
                                                input longint unsigned d);
    longint unsigned y;
    longint unsigned acc;
    y   = udiv64((d + i) << 30, d);
    acc = 0;
    for (int k = 15; k >= 0; k--) begin
      y = (y * y) >> 30;
      if (y >= (64'd2 << 30)) begin
        y   = y >> 1;
        acc = acc | (64'd1 << k);
      end
    end
    return acc;
  endfunction

  // 2^(-i/d) in Q.15 from chained square roots of one half
  function automatic longint unsigned exp_entry(input longint unsigned i,
                                                input longint unsigned d);
    longint unsigned roots [17];
    longint unsigned t;
    longint unsigned v;
    roots[0] = 0;
    roots[1] = isqrt64(64'd1 << 59);
    for (int k = 2; k <= 16; k++) roots[k] = isqrt64(roots[k-1] << 30);
    t = udiv64(i << 16, d);
    v = 64'd1 << 30;
    for (int k = 1; k <= 16; k++) begin
      if (((t >> (16 - k)) & 64'd1) != 0) v = (v * roots[k]) >> 30;
    end
    return v >> 15;
  endfunction

endpackage

>>> hdl/bpl_ctrl.sv
// ---------------------------------------------------------------------------
// Blinn-Phong accumulator controller
// Sequences dot products, root, divide, power and term steps per request.
// ---------------------------------------------------------------------------
module bpl_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output bpl_pkg::cmd_t cmd,
  input  bpl_pkg::sts_t sts
);

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_DOT     = 9'b000000010,
    ST_SQRT    = 9'b000000100,
    ST_DIV     = 9'b000001000,
    ST_POW_LOG = 9'b000010000,
    ST_POW_MUL = 9'b000100000,
    ST_POW_EXP = 9'b001000000,
    ST_TERM    = 9'b010000000,
    ST_FIN     = 9'b100000000
  } state_t;

  localparam logic [bpl_pkg::STEP_W-1:0] DOT_LAST  = 5'd8;
  localparam logic [bpl_pkg::STEP_W-1:0] SQRT_LAST = 5'd17;
  localparam logic [bpl_pkg::STEP_W-1:0] DIV_LAST  = 5'd14;
  localparam logic [bpl_pkg::STEP_W-1:0] TERM_LAST = 5'd23;

  state_t                      state_r, state_nxt;
  logic [bpl_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic                        out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.step      = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DOT;
          step_nxt  = '0;
        end
      end
      ST_DOT: begin
        cmd.dot = 1'b1;
        if (step_r == '0 && !sts.lit) begin
          state_nxt = ST_FIN;
        end else if (step_r == DOT_LAST) begin
          state_nxt = ST_SQRT;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + 5'd1;
        end
      end
      ST_SQRT: begin
        if (step_r == '0 && !sts.need_root) begin
          state_nxt = ST_POW_LOG;
        end else begin
          cmd.sqrt = 1'b1;
          if (step_r == SQRT_LAST) begin
            state_nxt = ST_DIV;
            step_nxt  = '0;
          end else begin
            step_nxt = step_r + 5'd1;
          end
        end
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (step_r == DIV_LAST) begin
          state_nxt = ST_POW_LOG;
        end else begin
          step_nxt = step_r + 5'd1;
        end
      end
      ST_POW_LOG: begin
        cmd.pow_log = 1'b1;
        state_nxt   = ST_POW_MUL;
      end
      ST_POW_MUL: begin
        cmd.pow_mul = 1'b1;
        state_nxt   = ST_POW_EXP;
      end
      ST_POW_EXP: begin
        cmd.pow_exp = 1'b1;
        state_nxt   = ST_TERM;
        step_nxt    = '0;
      end
      ST_TERM: begin
        cmd.term = 1'b1;
        if (step_r == TERM_LAST) begin
          state_nxt = ST_FIN;
        end else begin
          step_nxt = step_r + 5'd1;
        end
      end
      ST_FIN: begin
        if (!sts.last) begin
          state_nxt = ST_IDLE;
        end else if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

`include "blinn_phong_light_accumulator_assert.svh"

  `BPL_ASSERT_NEXT(a_load_to_dot, cmd.load, state_r == ST_DOT, "request not sequenced")
  `BPL_ASSERT_NEXT(a_emit_valid, cmd.emit, out_valid_r, "result not presented")
  `BPL_ASSERT_NOW(a_emit_slot, cmd.emit, !out_valid_r || out_ready, "result overwritten")
  `BPL_ASSERT_NEXT(a_term_to_fin, state_r == ST_TERM && step_r == TERM_LAST,
                   state_r == ST_FIN, "term sequence overran")

endmodule

>>> hdl/bpl_datapath.sv
// ---------------------------------------------------------------------------
// Blinn-Phong accumulator datapath
// Shared multiplier, iterative root and divide, power tables, accumulators.
// ---------------------------------------------------------------------------
module bpl_datapath #(
  parameter int unsigned LOG_TABLE_DEPTH = bpl_pkg::LOG_TABLE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  input  logic [47:0]   in_normal_xyz,
  input  logic [47:0]   in_view_xyz,
  input  logic [47:0]   in_light_dir_xyz,
  input  logic [15:0]   in_attenuation,
  input  logic [15:0]   in_light_red,
  input  logic [15:0]   in_light_green,
  input  logic [15:0]   in_light_blue,
  input  logic          in_lit,
  input  logic          in_last,
  input  bpl_pkg::cmd_t cmd,
  output bpl_pkg::sts_t sts,
  output logic [15:0]   out_red,
  output logic [15:0]   out_green,
  output logic [15:0]   out_blue
);

  localparam int unsigned IDX_W = $clog2(LOG_TABLE_DEPTH);
  localparam int unsigned IMW   = 14 + IDX_W + 1;
  localparam int unsigned JMW   = 16 + IDX_W + 1;

  logic [15:0] lt_rom [LOG_TABLE_DEPTH];
  logic [15:0] et_rom [LOG_TABLE_DEPTH];

  for (genvar gi = 0; gi < LOG_TABLE_DEPTH; gi++) begin : g_rom
    assign lt_rom[gi] = 16'(bpl_pkg::log_entry(64'(gi), 64'(LOG_TABLE_DEPTH)));
    assign et_rom[gi] = 16'(bpl_pkg::exp_entry(64'(gi), 64'(LOG_TABLE_DEPTH)));
  end

  logic [15:0]        cfg_r [bpl_pkg::NUM_REGS];
  logic signed [15:0] n_r   [3];
  logic signed [15:0] l_r   [3];
  logic signed [16:0] s_r   [3];
  logic [15:0]        col_r [3];
  logic [15:0]        att_r;
  logic               lit_r, last_r;

  logic signed [33:0] dln_r;
  logic signed [35:0] sn_r;
  logic [35:0]        ss_r;

  logic [35:0] sq_src_r;
  logic [19:0] sq_rem_r;
  logic [17:0] root_r;
  logic [31:0] dv_rem_r, dv_r;
  logic [13:0] hn_r;
  logic        sat_r;
  logic [19:0] npow_r;
  logic        zb_r;
  logic [27:0] e_r;
  logic [15:0] powv_r;
  logic [21:0] tp_r;
  logic [23:0] sum_r [3];
  logic [15:0] out_r [3];

  logic signed [20:0] mul_a, mul_b;
  logic signed [41:0] mul_p;
  logic [1:0]         dot_k, dot_g;
  logic [2:0]         ti;
  logic [1:0]         ph, ch;
  logic               diff;
  logic [17:0]        ndl;

  always_comb begin
    case (cmd.step) inside
      5'd0, 5'd3, 5'd6: dot_k = 2'd0;
      5'd1, 5'd4, 5'd7: dot_k = 2'd1;
      default:          dot_k = 2'd2;
    endcase
    if (cmd.step < 5'd3)      dot_g = 2'd0;
    else if (cmd.step < 5'd6) dot_g = 2'd1;
    else                      dot_g = 2'd2;
  end

  assign ti   = cmd.step[4:2];
  assign ph   = cmd.step[1:0];
  assign diff = (ti < 3'd3);
  assign ch   = diff ? ti[1:0] : 2'(ti - 3'd3);
  assign ndl  = (dln_r > 34'sd0) ? dln_r[31:14] : '0;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.dot) begin
      case (dot_g)
        2'd0:    begin mul_a = 21'(l_r[dot_k]); mul_b = 21'(n_r[dot_k]); end
        2'd1:    begin mul_a = 21'(s_r[dot_k]); mul_b = 21'(n_r[dot_k]); end
        default: begin mul_a = 21'(s_r[dot_k]); mul_b = 21'(s_r[dot_k]); end
      endcase
    end else if (cmd.pow_mul) begin
      mul_a = $signed({1'b0, npow_r});
      mul_b = $signed({5'b0, cfg_r[6]});
    end else if (cmd.term) begin
      case (ph)
        2'd0: begin
          mul_a = $signed({5'b0, col_r[ch]});
          mul_b = $signed({5'b0, cfg_r[ti]});
        end
        2'd1: begin
          mul_a = $signed({3'b0, tp_r[17:0]});
          mul_b = $signed({5'b0, att_r});
        end
        default: begin
          mul_a = $signed({3'b0, tp_r[17:0]});
          mul_b = diff ? $signed({3'b0, ndl}) : $signed({5'b0, powv_r});
        end
      endcase
    end
  end

  assign mul_p = mul_a * mul_b;

  // root digit step
  logic [35:0] sq_src;
  logic [19:0] sq_rem_in;
  logic [17:0] root_in;
  logic [21:0] sq_rem_t, sq_trial;
  logic        sq_ge;

  assign sq_src    = (cmd.step == '0) ? ss_r : sq_src_r;
  assign sq_rem_in = (cmd.step == '0) ? '0 : sq_rem_r;
  assign root_in   = (cmd.step == '0) ? '0 : root_r;
  assign sq_rem_t  = {sq_rem_in, sq_src[35:34]};
  assign sq_trial  = {2'b0, root_in, 2'b01};
  assign sq_ge     = (sq_rem_t >= sq_trial);

  // power: log stage
  logic [14:0]      base;
  logic [3:0]       top, lsh;
  logic [14:0]      mant;
  logic [IMW-1:0]   idx_prod;
  logic [IDX_W-1:0] idx;
  logic [JMW-1:0]   j_prod;
  logic [IDX_W-1:0] jdx;
  logic [15:0]      pv;

  assign base = sat_r ? 15'd16384 : {1'b0, hn_r};

  always_comb begin
    top = '0;
    for (int i = 0; i < 15; i++) begin
      if (base[i]) top = 4'(i);
    end
  end

  assign lsh      = 4'd14 - top;
  assign mant     = base << lsh;
  assign idx_prod = IMW'(mant[13:0]) * IMW'(LOG_TABLE_DEPTH);
  assign idx      = idx_prod[14 +: IDX_W];
  assign j_prod   = JMW'(e_r[15:0]) * JMW'(LOG_TABLE_DEPTH);
  assign jdx      = j_prod[16 +: IDX_W];
  assign pv       = et_rom[jdx] >> e_r[19:16];

  logic [24:0] sum_add;
  assign sum_add = 25'(sum_r[ch]) + 25'(tp_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) cfg_r[i] <= bpl_pkg::REFL_RESET;
      cfg_r[6] <= bpl_pkg::SHIN_RESET;
      for (int i = 0; i < 3; i++) sum_r[i] <= '0;
    end else begin
      if (cfg_we && (32'(cfg_index) < bpl_pkg::NUM_REGS)) cfg_r[cfg_index] <= cfg_data;
      if (cmd.term && ph == 2'd3) sum_r[ch] <= sum_add[24] ? '1 : sum_add[23:0];
      if (cmd.emit) begin
        for (int i = 0; i < 3; i++) sum_r[i] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < 3; k++) begin
        n_r[k] <= in_normal_xyz[16*k +: 16];
        l_r[k] <= in_light_dir_xyz[16*k +: 16];
        s_r[k] <= $signed({in_light_dir_xyz[16*k+15], in_light_dir_xyz[16*k +: 16]})
                + $signed({in_view_xyz[16*k+15], in_view_xyz[16*k +: 16]});
      end
      col_r[0] <= in_light_red;
      col_r[1] <= in_light_green;
      col_r[2] <= in_light_blue;
      att_r    <= in_attenuation;
      lit_r    <= in_lit;
      last_r   <= in_last;
      dln_r    <= '0;
      sn_r     <= '0;
      ss_r     <= '0;
      hn_r     <= '0;
      sat_r    <= 1'b0;
    end
    if (cmd.dot) begin
      case (dot_g)
        2'd0:    dln_r <= dln_r + 34'(mul_p);
        2'd1:    sn_r  <= sn_r + 36'(mul_p);
        default: ss_r  <= ss_r + mul_p[35:0];
      endcase
    end
    if (cmd.sqrt) begin
      sq_src_r <= sq_src << 2;
      if (sq_ge) begin
        sq_rem_r <= 20'(sq_rem_t - sq_trial);
        root_r   <= {root_in[16:0], 1'b1};
      end else begin
        sq_rem_r <= sq_rem_t[19:0];
        root_r   <= {root_in[16:0], 1'b0};
      end
    end
    if (cmd.div) begin
      if (cmd.step == '0) begin
        sat_r    <= (sn_r[34:0] >= 35'({root_r, 14'b0}));
        dv_rem_r <= sn_r[31:0];
        dv_r     <= 32'({root_r, 13'b0});
        hn_r     <= '0;
      end else begin
        if (dv_rem_r >= dv_r) dv_rem_r <= dv_rem_r - dv_r;
        hn_r <= {hn_r[12:0], (dv_rem_r >= dv_r)};
        dv_r <= dv_r >> 1;
      end
    end
    if (cmd.pow_log) begin
      zb_r   <= (base == '0);
      npow_r <= {lsh, 16'b0} - {4'b0, lt_rom[idx]};
    end
    if (cmd.pow_mul) e_r <= mul_p[35:8];
    if (cmd.pow_exp) begin
      if (ss_r == '0)       powv_r <= '0;
      else if (zb_r)        powv_r <= (cfg_r[6] == '0) ? 16'd32768 : '0;
      else if (|e_r[27:20]) powv_r <= '0;
      else                  powv_r <= pv;
    end
    if (cmd.term) begin
      case (ph)
        2'd0:    tp_r <= 22'(mul_p[31:15]);
        2'd1:    tp_r <= 22'(mul_p[32:15]);
        2'd2:    tp_r <= diff ? mul_p[35:14] : 22'(mul_p[34:15]);
        default: tp_r <= tp_r;
      endcase
    end
    if (cmd.emit) begin
      for (int i = 0; i < 3; i++)
        out_r[i] <= (sum_r[i] > 24'd32768) ? 16'd32768 : sum_r[i][15:0];
    end
  end

  assign sts.lit       = lit_r;
  assign sts.last      = last_r;
  assign sts.need_root = (ss_r != '0) && (sn_r > 36'sd0);

  assign out_red   = out_r[0];
  assign out_green = out_r[1];
  assign out_blue  = out_r[2];

endmodule

>>> hdl/blinn_phong_light_accumulator.sv
// An unlit request goes from the dot state straight to finish, then to idle.
// A lit request skips the half-vector root and divide when no root is needed.
// One request at a time: in_ready is high only while idle. The root takes
// 18 steps, the divide 15 and the shared-multiplier term sequence 24.
// Reset (rst_n, synchronous): config registers to defaults, sums cleared, no result.
// ---------------------------------------------------------------------------
// Blinn-Phong light accumulator
// Accumulates diffuse and specular light per point and emits clamped RGB.
// ---------------------------------------------------------------------------
module blinn_phong_light_accumulator #(
  parameter int unsigned LOG_TABLE_DEPTH = bpl_pkg::LOG_TABLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [47:0] in_normal_xyz,
  input  logic [47:0] in_view_xyz,
  input  logic [47:0] in_light_dir_xyz,
  input  logic [15:0] in_attenuation,
  input  logic [15:0] in_light_red,
  input  logic [15:0] in_light_green,
  input  logic [15:0] in_light_blue,
  input  logic        in_lit,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_red,
  output logic [15:0] out_green,
  output logic [15:0] out_blue
);

  bpl_pkg::cmd_t cmd;
  bpl_pkg::sts_t sts;

  bpl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  bpl_datapath #(
    .LOG_TABLE_DEPTH (LOG_TABLE_DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_normal_xyz    (in_normal_xyz),
    .in_view_xyz      (in_view_xyz),
    .in_light_dir_xyz (in_light_dir_xyz),
    .in_attenuation   (in_attenuation),
    .in_light_red     (in_light_red),
    .in_light_green   (in_light_green),
    .in_light_blue    (in_light_blue),
    .in_lit           (in_lit),
    .in_last          (in_last),
    .cmd              (cmd),
    .sts              (sts),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue)
  );

endmodule
